// ----- rtl/rrun_pkg.sv -----
// Shared types and constants for the relative relocation unapply unit.
`default_nettype none

package rrun_pkg;

    localparam int unsigned DATA_W          = 64;
    localparam int unsigned ADDR_EXT_W      = DATA_W + 1;
    localparam int unsigned IMG_SIZE_W      = 30;
    localparam int unsigned CFG_IDX_W       = 8;
    localparam int unsigned BITMAP_SLOTS_DEF = 63;
    localparam int unsigned SLOT_BYTES      = 8;

    localparam logic [31:0] RELATIVE_TYPE = 32'd1027;

    typedef enum logic [1:0] {
        ACT_RELA  = 2'd0,
        ACT_RELR  = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_SUB   = 1'b1
    } write_op_t;

    localparam logic [CFG_IDX_W-1:0] IDX_IMAGE_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] IDX_LOAD_BASE  = CFG_IDX_W'(1);

    typedef struct packed {
        logic [1:0]        action;
        logic [DATA_W-1:0] target_offset;
        logic [DATA_W-1:0] info_word;
        logic [DATA_W-1:0] addend_value;
        logic [DATA_W-1:0] relr_word;
    } req_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] slot_address;
        logic              write_op;
        logic [DATA_W-1:0] op_value;
        logic              last_of_run;
    } cmd_item_t;

endpackage

`default_nettype wire

// ----- rtl/relative_relocation_unapply_unit.sv -----
// Top level: relocation table items in, slot write commands out.
// An accepted item is registered, the scan state tests its slots and the flush
//   state issues the last pending command; a bitmap word is scanned to its highest set
//   bit (at least one), one slot tested per cycle unless a full output holds the scan.
// One item at a time; start and non-matching items skip the scan; a full output stalls.
// Reset (rst_n, async, active low): idle, cursor and registers cleared, no item held.
`default_nettype none

module relative_relocation_unapply_unit
    import rrun_pkg::*;
#(
    parameter int unsigned BITMAP_SLOTS = BITMAP_SLOTS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request channel
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire req_item_t            req,
    // command channel
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output cmd_item_t                 cmd,
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    localparam int unsigned CNT_W = $clog2(BITMAP_SLOTS + 1);
    localparam logic [DATA_W-1:0] BITMAP_SPAN = DATA_W'(BITMAP_SLOTS * SLOT_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [IMG_SIZE_W-1:0]   image_size_reg;
    logic [DATA_W-1:0]       load_base_reg;
    logic [DATA_W-1:0]       cursor_reg, cursor_next;
    logic [ADDR_EXT_W-1:0]   addr_reg, addr_next;
    logic [BITMAP_SLOTS-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    op_reg, op_next;
    logic [DATA_W-1:0]       val_reg, val_next;
    logic [DATA_W-1:0]       pend_addr_reg, pend_addr_next;
    logic                    pend_valid_reg, pend_valid_next;
    cmd_item_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    fits;
    logic [ADDR_EXT_W-1:0]   addr_step;
    logic                    req_fire;
    logic                    out_free;
    logic                    hit;
    logic                    can_step;
    logic                    type_match;

    rrun_slot_unit u_slot (
        .addr       (addr_reg),
        .image_size (image_size_reg),
        .fits       (fits),
        .addr_step  (addr_step)
    );

    assign req_ready  = (state_reg == ST_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign cfg_ready  = 1'b1;
    assign cmd_valid  = out_valid_reg;
    assign cmd        = out_reg;

    assign out_free   = !out_valid_reg || cmd_ready;
    assign hit        = bits_reg[0] && fits;
    // A found slot pushes the previous one out; wait if the output is still full.
    assign can_step   = !(hit && pend_valid_reg && !out_free);
    assign type_match = (req.info_word[31:0] == RELATIVE_TYPE);

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        addr_next       = addr_reg;
        bits_next       = bits_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        pend_addr_next  = pend_addr_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !cmd_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.action)
                        ACT_RELA:
                        begin
                            // one candidate slot, no cursor involvement
                            addr_next  = {1'b0, req.target_offset};
                            bits_next  = BITMAP_SLOTS'(type_match);
                            count_next = CNT_W'(1);
                            op_next    = OP_STORE;
                            val_next   = req.addend_value;
                            if (type_match)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_RELR:
                        begin
                            op_next    = OP_SUB;
                            val_next   = load_base_reg;
                            state_next = ST_SCAN;
                            if (!req.relr_word[0])
                            begin
                                // address word: one slot, cursor moves past it
                                addr_next   = {1'b0, req.relr_word};
                                bits_next   = BITMAP_SLOTS'(1);
                                count_next  = CNT_W'(1);
                                cursor_next = req.relr_word + DATA_W'(SLOT_BYTES);
                            end
                            else
                            begin
                                // bitmap word: walk the slots starting at the cursor
                                addr_next   = {1'b0, cursor_reg};
                                bits_next   = req.relr_word[BITMAP_SLOTS:1];
                                count_next  = CNT_W'(BITMAP_SLOTS);
                                cursor_next = cursor_reg + BITMAP_SPAN;
                            end
                        end
                        ACT_START:
                        begin
                            cursor_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (can_step)
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = '{slot_address: pend_addr_reg,
                                               write_op:     op_reg,
                                               op_value:     val_reg,
                                               last_of_run:  1'b0};
                            out_valid_next = 1'b1;
                        end
                        pend_addr_next  = addr_reg[DATA_W-1:0];
                        pend_valid_next = 1'b1;
                    end
                    addr_next  = addr_step;
                    bits_next  = bits_reg >> 1;
                    count_next = count_reg - CNT_W'(1);
                    // stop early once no set bits remain
                    if ((count_reg == CNT_W'(1)) || (bits_reg[BITMAP_SLOTS-1:1] == '0))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = '{slot_address: pend_addr_reg,
                                        write_op:     op_reg,
                                        op_value:     val_reg,
                                        last_of_run:  1'b1};
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            image_size_reg <= '0;
            load_base_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == IDX_IMAGE_SIZE)
                begin
                    image_size_reg <= cfg_data[IMG_SIZE_W-1:0];
                end
                else if (cfg_index == IDX_LOAD_BASE)
                begin
                    load_base_reg <= cfg_data;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        bits_reg      <= bits_next;
        count_reg     <= count_next;
        op_reg        <= op_next;
        val_reg       <= val_next;
        pend_addr_reg <= pend_addr_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

// ----- rtl/rrun_slot_unit.sv -----
// Shared slot unit: bounds check of one slot and step to the next slot.
`default_nettype none

module rrun_slot_unit
    import rrun_pkg::*;
(
    input  wire logic [ADDR_EXT_W-1:0] addr,
    input  wire logic [IMG_SIZE_W-1:0] image_size,
    output logic                       fits,
    output logic [ADDR_EXT_W-1:0]      addr_step
);

    logic                  size_ok;
    logic [IMG_SIZE_W-1:0] room;

    // Exact test addr + 8 <= image_size; addr carries a 65th bit so no wrap.
    assign size_ok   = (image_size >= IMG_SIZE_W'(SLOT_BYTES));
    assign room      = image_size - IMG_SIZE_W'(SLOT_BYTES);
    assign fits      = size_ok
                       && (addr[ADDR_EXT_W-1:IMG_SIZE_W] == '0)
                       && (addr[IMG_SIZE_W-1:0] <= room);
    assign addr_step = addr + ADDR_EXT_W'(SLOT_BYTES);

endmodule

`default_nettype wire

// ----- rtl/rrun_checker.sv -----
// Port-level assertions for the relative relocation unapply unit, with bind.
`default_nettype none

module rrun_checker
    import rrun_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_valid,
    input wire logic      req_ready,
    input wire req_item_t req,
    input wire logic      cmd_valid,
    input wire logic      cmd_ready,
    input wire cmd_item_t cmd
);

    // a stalled command holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("command changed while stalled");

    // start-of-table items keep the unit ready for the next item
    a_start_quick: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.action == ACT_START) |=> req_ready)
        else $error("not ready after start of table");

    // RELR words always occupy the sequencer
    a_relr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.action == ACT_RELR) |=> !req_ready)
        else $error("ready straight after RELR word");

    // store commands come from RELA entries, always alone
    a_store_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd.write_op == OP_STORE) |-> cmd.last_of_run)
        else $error("store command not last of run");

    // every slot lies inside the image, below 2^30
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (cmd.slot_address[DATA_W-1:IMG_SIZE_W] == '0))
        else $error("slot address beyond image bound");

endmodule

bind relative_relocation_unapply_unit rrun_checker u_rrun_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
);

`default_nettype wire
